// ----- hw/rtl/pwft_pkg.sv -----
package pwft_pkg;

    typedef enum logic [2:0] {
        PH_KEY,
        PH_VALUE,
        PH_FIXED,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_DISCARD
    } phase_t;

    localparam logic [1:0] KIND_SCALAR  = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_TRUNC_VARINT  = 3'd1;
    localparam logic [2:0] ERR_LONG_VARINT   = 3'd2;
    localparam logic [2:0] ERR_TRUNC_FIXED   = 3'd3;
    localparam logic [2:0] ERR_TRUNC_PAYLOAD = 3'd4;
    localparam logic [2:0] ERR_BAD_WIRE      = 3'd5;

    localparam logic [2:0] WIRE_VARINT = 3'd0;
    localparam logic [2:0] WIRE_I64    = 3'd1;
    localparam logic [2:0] WIRE_LEN    = 3'd2;
    localparam logic [2:0] WIRE_I32    = 3'd5;

    localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] field_number;
        logic [2:0]  wire_type;
        logic [63:0] field_value;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic [2:0]  error_code;
        logic        message_end;
    } result_t;

endpackage

// ----- hw/rtl/pwft_core.sv -----
module pwft_core
    import pwft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        message_last,
    output logic        res_valid,
    output result_t     res
);

    phase_t      phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  count_reg, count_next;
    logic [31:0] field_reg, field_next;
    logic [2:0]  wire_reg, wire_next;
    logic [63:0] rem_reg, rem_next;

    logic        cnt_full;
    logic        more;
    logic [5:0]  vshift;
    logic [63:0] varint_acc;
    logic [31:0] key_field;
    logic [2:0]  key_wire;
    logic [3:0]  fixed_width;
    logic [2:0]  fixed_idx;
    logic [63:0] fixed_acc;
    logic        rem_one;
    logic [3:0]  count_inc;

    assign cnt_full    = (count_reg >= VARINT_MAX_BYTES);
    assign more        = data_byte[7];
    assign vshift      = 6'({2'b00, count_reg} * 6'd7);
    assign varint_acc  = acc_reg | ({57'd0, data_byte[6:0]} << vshift);
    assign key_field   = varint_acc[34:3];
    assign key_wire    = varint_acc[2:0];
    assign fixed_width = (wire_reg == WIRE_I64) ? 4'd8 : 4'd4;
    assign fixed_idx   = 3'(fixed_width - rem_reg[3:0]);
    assign fixed_acc   = acc_reg | ({56'd0, data_byte} << {fixed_idx, 3'b000});
    assign rem_one     = (rem_reg == 64'd1);
    assign count_inc   = count_reg + 4'd1;

    // next parser state
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        field_next = field_reg;
        wire_next  = wire_reg;
        rem_next   = rem_reg;
        unique case (phase_reg)
            PH_KEY:
            begin
                if (cnt_full)
                begin
                    phase_next = PH_DISCARD;
                end
                else if (more)
                begin
                    acc_next   = varint_acc;
                    count_next = count_inc;
                end
                else
                begin
                    field_next = key_field;
                    wire_next  = key_wire;
                    acc_next   = '0;
                    count_next = '0;
                    if (key_wire == WIRE_VARINT)
                    begin
                        phase_next = PH_VALUE;
                    end
                    else if (key_wire == WIRE_I64 || key_wire == WIRE_I32)
                    begin
                        rem_next   = (key_wire == WIRE_I64) ? 64'd8 : 64'd4;
                        phase_next = PH_FIXED;
                    end
                    else if (key_wire == WIRE_LEN)
                    begin
                        phase_next = PH_LENGTH;
                    end
                    else
                    begin
                        phase_next = PH_DISCARD;
                    end
                end
            end
            PH_VALUE, PH_LENGTH:
            begin
                if (cnt_full)
                begin
                    phase_next = PH_DISCARD;
                end
                else if (more)
                begin
                    acc_next   = varint_acc;
                    count_next = count_inc;
                end
                else
                begin
                    acc_next   = '0;
                    count_next = '0;
                    if (phase_reg == PH_VALUE || varint_acc == 64'd0)
                    begin
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        rem_next   = varint_acc;
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_FIXED:
            begin
                rem_next = rem_reg - 64'd1;
                if (rem_one)
                begin
                    acc_next   = '0;
                    phase_next = PH_KEY;
                end
                else
                begin
                    acc_next = fixed_acc;
                end
            end
            PH_PAYLOAD:
            begin
                rem_next = rem_reg - 64'd1;
                if (rem_one)
                begin
                    phase_next = PH_KEY;
                end
            end
            PH_DISCARD:
            begin
            end
            default:
            begin
                phase_next = PH_KEY;
            end
        endcase
        // the end of message clears every parser register, so a truncated field needs no discard
        if (message_last)
        begin
            phase_next = PH_KEY;
            acc_next   = '0;
            count_next = '0;
            field_next = '0;
            wire_next  = '0;
            rem_next   = '0;
        end
    end

    // result for this byte
    always_comb
    begin
        res_valid        = 1'b0;
        res.kind         = KIND_SCALAR;
        res.field_number = field_reg;
        res.wire_type    = wire_reg;
        res.field_value  = '0;
        res.payload_byte = '0;
        res.payload_last = 1'b0;
        res.error_code   = ERR_NONE;
        res.message_end  = message_last;
        unique case (phase_reg)
            PH_KEY:
            begin
                res.kind = KIND_ERROR;
                if (cnt_full)
                begin
                    res_valid        = 1'b1;
                    res.field_number = '0;
                    res.wire_type    = '0;
                    res.error_code   = ERR_LONG_VARINT;
                end
                else if (more)
                begin
                    res_valid        = message_last;
                    res.field_number = '0;
                    res.wire_type    = '0;
                    res.error_code   = ERR_TRUNC_VARINT;
                end
                else
                begin
                    res.field_number = key_field;
                    res.wire_type    = key_wire;
                    if (key_wire == WIRE_VARINT || key_wire == WIRE_LEN)
                    begin
                        res_valid      = message_last;
                        res.error_code = ERR_TRUNC_VARINT;
                    end
                    else if (key_wire == WIRE_I64 || key_wire == WIRE_I32)
                    begin
                        res_valid      = message_last;
                        res.error_code = ERR_TRUNC_FIXED;
                    end
                    else
                    begin
                        res_valid      = 1'b1;
                        res.error_code = ERR_BAD_WIRE;
                    end
                end
            end
            PH_VALUE, PH_LENGTH:
            begin
                if (cnt_full)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_LONG_VARINT;
                end
                else if (more)
                begin
                    res_valid      = message_last;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_TRUNC_VARINT;
                end
                else if (phase_reg == PH_VALUE)
                begin
                    res_valid       = 1'b1;
                    res.field_value = varint_acc;
                end
                else if (varint_acc != 64'd0 && message_last)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_TRUNC_PAYLOAD;
                end
                else
                begin
                    res_valid       = 1'b1;
                    res.kind        = KIND_HEADER;
                    res.field_value = varint_acc;
                end
            end
            PH_FIXED:
            begin
                if (rem_one)
                begin
                    res_valid       = 1'b1;
                    res.field_value = fixed_acc;
                end
                else
                begin
                    res_valid      = message_last;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_TRUNC_FIXED;
                end
            end
            PH_PAYLOAD:
            begin
                res_valid = 1'b1;
                if (!rem_one && message_last)
                begin
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_TRUNC_PAYLOAD;
                end
                else
                begin
                    res.kind         = KIND_PAYLOAD;
                    res.payload_byte = data_byte;
                    res.payload_last = rem_one;
                end
            end
            PH_DISCARD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_KEY;
            acc_reg   <= '0;
            count_reg <= '0;
            field_reg <= '0;
            wire_reg  <= '0;
            rem_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
            field_reg <= field_next;
            wire_reg  <= wire_next;
            rem_reg   <= rem_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= VARINT_MAX_BYTES)
        else $error("varint byte count past ten");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && message_last |=> phase_reg == PH_KEY && acc_reg == 64'd0
            && count_reg == 4'd0 && rem_reg == 64'd0)
        else $error("parser not cleared after end of message");

    a_fixed_rem: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FIXED |-> rem_reg != 64'd0 && rem_reg <= 64'd8)
        else $error("fixed byte count out of range");

    a_payload_rem: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> rem_reg != 64'd0)
        else $error("payload phase with nothing owed");

    a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DISCARD |-> !res_valid)
        else $error("result raised while discarding");

endmodule

// ----- hw/rtl/protobuf_wire_field_tokenizer.sv -----
// channel  | valid        | ready        | payload
// byte     | byte_valid   | byte_ready   | data_byte, message_last
// token    | token_valid  | token_ready  | kind, field_number, wire_type, field_value,
//          |              |              | payload_byte, payload_last, error_code, message_end
//
// one byte per cycle while byte_ready is high: each request is decoded in the cycle
// it is taken and its token, if any, lands in the output register on that edge
// byte_ready drops only while the output register is full and token_ready is low
// rst_n clears the parser to the key phase and empties the output register
module protobuf_wire_field_tokenizer
    import pwft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  data_byte,
    input  logic        message_last,
    output logic        token_valid,
    input  logic        token_ready,
    output logic [1:0]  kind,
    output logic [31:0] field_number,
    output logic [2:0]  wire_type,
    output logic [63:0] field_value,
    output logic [7:0]  payload_byte,
    output logic        payload_last,
    output logic [2:0]  error_code,
    output logic        message_end
);

    logic    accept;
    logic    res_valid;
    result_t res;
    logic    out_valid_reg;
    result_t out_reg;

    assign byte_ready = !out_valid_reg || token_ready;
    assign accept     = byte_valid && byte_ready;

    pwft_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (data_byte),
        .message_last (message_last),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (byte_ready)
        begin
            out_valid_reg <= accept && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign token_valid  = out_valid_reg;
    assign kind         = out_reg.kind;
    assign field_number = out_reg.field_number;
    assign wire_type    = out_reg.wire_type;
    assign field_value  = out_reg.field_value;
    assign payload_byte = out_reg.payload_byte;
    assign payload_last = out_reg.payload_last;
    assign error_code   = out_reg.error_code;
    assign message_end  = out_reg.message_end;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import pwft_pkg::*;

    localparam int GRP_MORE = 0;
    localparam int GRP_DONE = 1;
    localparam int GRP_LONG = 2;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         hold;
    } byte_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_ready;
    logic [7:0]  data_byte = '0;
    logic        message_last = 1'b0;
    logic        token_valid;
    logic        token_ready = 1'b0;
    logic [1:0]  kind;
    logic [31:0] field_number;
    logic [2:0]  wire_type;
    logic [63:0] field_value;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [2:0]  error_code;
    logic        message_end;

    protobuf_wire_field_tokenizer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .data_byte    (data_byte),
        .message_last (message_last),
        .token_valid  (token_valid),
        .token_ready  (token_ready),
        .kind         (kind),
        .field_number (field_number),
        .wire_type    (wire_type),
        .field_value  (field_value),
        .payload_byte (payload_byte),
        .payload_last (payload_last),
        .error_code   (error_code),
        .message_end  (message_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    byte_req_t   byte_reqs[$];
    result_t     expected_tokens[$];
    logic [7:0]  msg[$];
    int          errors = 0;
    int          n_accepted = 0;
    int          tokens_seen = 0;
    logic        byte_took = 1'b0;

    // parser state mirrored by the predictor
    phase_t      ph = PH_KEY;
    logic [63:0] acc = '0;
    int unsigned vcnt = 0;
    logic [31:0] cur_field = '0;
    logic [2:0]  cur_wire = '0;
    logic [63:0] owed = '0;

    function automatic int take_group(input logic [7:0] b);
        logic [63:0] grp;
        if (vcnt >= VARINT_MAX_BYTES)
            return GRP_LONG;
        grp = {57'd0, b[6:0]};
        acc = acc | (grp << (7 * vcnt));
        vcnt++;
        return b[7] ? GRP_MORE : GRP_DONE;
    endfunction

    function automatic result_t make_token(input logic [1:0] k, input bit keyed,
                                           input logic [63:0] val, input logic [7:0] pb,
                                           input logic pl, input logic [2:0] ec,
                                           input logic last);
        result_t t;
        t.kind         = k;
        t.field_number = keyed ? cur_field : '0;
        t.wire_type    = keyed ? cur_wire : '0;
        t.field_value  = val;
        t.payload_byte = pb;
        t.payload_last = pl;
        t.error_code   = ec;
        t.message_end  = last;
        return t;
    endfunction

    function automatic result_t fault(input logic [2:0] code, input bit keyed, input logic last);
        ph = PH_DISCARD;
        return make_token(KIND_ERROR, keyed, '0, '0, 1'b0, code, last);
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output result_t tok);
        int         g;
        bit         hit;
        logic [3:0] wbytes;
        logic [3:0] widx;
        hit = 1'b0;
        tok = '0;
        case (ph)
            PH_DISCARD: ;
            PH_VALUE, PH_LENGTH:
            begin
                g = take_group(b);
                if (g == GRP_LONG)
                begin
                    tok = fault(ERR_LONG_VARINT, 1'b1, last);
                    hit = 1'b1;
                end
                else if (g == GRP_MORE)
                begin
                    if (last)
                    begin
                        tok = fault(ERR_TRUNC_VARINT, 1'b1, last);
                        hit = 1'b1;
                    end
                end
                else
                begin
                    hit = 1'b1;
                    if (ph == PH_VALUE)
                    begin
                        tok = make_token(KIND_SCALAR, 1'b1, acc, '0, 1'b0, ERR_NONE, last);
                        ph = PH_KEY;
                    end
                    else if (acc == 0)
                    begin
                        tok = make_token(KIND_HEADER, 1'b1, '0, '0, 1'b0, ERR_NONE, last);
                        ph = PH_KEY;
                    end
                    else if (last)
                        tok = fault(ERR_TRUNC_PAYLOAD, 1'b1, last);
                    else
                    begin
                        tok = make_token(KIND_HEADER, 1'b1, acc, '0, 1'b0, ERR_NONE, last);
                        owed = acc;
                        ph = PH_PAYLOAD;
                    end
                    acc = '0;
                    vcnt = 0;
                end
            end
            PH_FIXED:
            begin
                wbytes = (cur_wire == WIRE_I64) ? 4'd8 : 4'd4;
                widx = wbytes - owed[3:0];
                acc = acc | ({56'd0, b} << (8 * widx[2:0]));
                if (owed != 0)
                    owed--;
                if (owed == 0)
                begin
                    tok = make_token(KIND_SCALAR, 1'b1, acc, '0, 1'b0, ERR_NONE, last);
                    hit = 1'b1;
                    acc = '0;
                    ph = PH_KEY;
                end
                else if (last)
                begin
                    tok = fault(ERR_TRUNC_FIXED, 1'b1, last);
                    hit = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                if (owed != 0)
                    owed--;
                hit = 1'b1;
                if (owed == 0)
                begin
                    tok = make_token(KIND_PAYLOAD, 1'b1, '0, b, 1'b1, ERR_NONE, last);
                    ph = PH_KEY;
                end
                else if (last)
                    tok = fault(ERR_TRUNC_PAYLOAD, 1'b1, last);
                else
                    tok = make_token(KIND_PAYLOAD, 1'b1, '0, b, 1'b0, ERR_NONE, last);
            end
            default:
            begin
                g = take_group(b);
                if (g == GRP_LONG)
                begin
                    tok = fault(ERR_LONG_VARINT, 1'b0, last);
                    hit = 1'b1;
                end
                else if (g == GRP_MORE)
                begin
                    if (last)
                    begin
                        tok = fault(ERR_TRUNC_VARINT, 1'b0, last);
                        hit = 1'b1;
                    end
                end
                else
                begin
                    cur_field = acc[34:3];
                    cur_wire = acc[2:0];
                    acc = '0;
                    vcnt = 0;
                    if (cur_wire == WIRE_VARINT || cur_wire == WIRE_LEN)
                    begin
                        if (last)
                        begin
                            tok = fault(ERR_TRUNC_VARINT, 1'b1, last);
                            hit = 1'b1;
                        end
                        else
                            ph = (cur_wire == WIRE_VARINT) ? PH_VALUE : PH_LENGTH;
                    end
                    else if (cur_wire == WIRE_I64 || cur_wire == WIRE_I32)
                    begin
                        if (last)
                        begin
                            tok = fault(ERR_TRUNC_FIXED, 1'b1, last);
                            hit = 1'b1;
                        end
                        else
                        begin
                            owed = (cur_wire == WIRE_I64) ? 64'd8 : 64'd4;
                            ph = PH_FIXED;
                        end
                    end
                    else
                    begin
                        tok = fault(ERR_BAD_WIRE, 1'b1, last);
                        hit = 1'b1;
                    end
                end
            end
        endcase
        if (last)
        begin
            ph = PH_KEY;
            acc = '0;
            vcnt = 0;
            cur_field = '0;
            cur_wire = '0;
            owed = '0;
        end
        return hit;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endfunction

    // stimulus builders

    function automatic int pad_len();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
    endfunction

    function automatic logic [63:0] rand_wide();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return '0;
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    // len asks for redundant continuation groups; only the minimal length is capped at ten bytes
    task automatic put_varint(input logic [63:0] v, input int len);
        int         n;
        logic [6:0] grp;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != 0)
            n++;
        if (len > n)
            n = len;
        for (int i = 0; i < n; i++)
        begin
            grp = 7'(v >> (7 * i));
            // tenth group: junk above bit 63 must be dropped
            if (i == 9 && $urandom_range(0, 2) == 0)
                grp = {6'($urandom), v[63]};
            msg.insert(msg.size(), {(i < n - 1) ? 1'b1 : 1'b0, grp});
        end
    endtask

    task automatic put_field();
        logic [63:0] fnum;
        logic [2:0]  w;
        int          n;
        case ($urandom_range(0, 5))
            0: fnum = $urandom_range(1, 15);
            1: fnum = 64'hFFFF_FFFF;
            2: fnum = {32'd0, $urandom};
            3: fnum = rand_wide();
            default: fnum = $urandom_range(0, 2047);
        endcase
        case ($urandom_range(0, 3))
            0: w = WIRE_VARINT;
            1: w = WIRE_I64;
            2: w = WIRE_LEN;
            default: w = WIRE_I32;
        endcase
        put_varint({fnum[60:0], w}, pad_len());
        if (w == WIRE_VARINT)
            put_varint(rand_wide(), pad_len());
        else if (w == WIRE_LEN)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 5);
            put_varint(64'(n), pad_len());
            repeat (n) msg.insert(msg.size(), 8'($urandom));
        end
        else
        begin
            n = (w == WIRE_I64) ? 8 : 4;
            repeat (n) msg.insert(msg.size(), 8'($urandom));
        end
    endtask

    task automatic queue_message(input bit hold);
        byte_req_t r;
        foreach (msg[i])
        begin
            r.data = msg[i];
            r.last = (i == msg.size() - 1);
            r.hold = hold && (i == 0);
            byte_reqs.insert(byte_reqs.size(), r);
        end
        msg.delete();
    endtask

    // sender: bursts and gaps, changes only at the falling edge
    int        burst_left = 1;
    int        gap_left = 0;
    byte_req_t req;

    always @(negedge clk)
    begin
        if (rst_n && !(byte_valid && !byte_took))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                byte_valid <= 1'b0;
            end
            else if (byte_reqs.size() == 0 ||
                     (byte_reqs[0].hold && expected_tokens.size() != 0))
                byte_valid <= 1'b0;
            else
            begin
                req = byte_reqs.pop_front();
                byte_valid <= 1'b1;
                data_byte <= req.data;
                message_last <= req.last;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 16)
                                                           : $urandom_range(0, 2);
                end
                else
                    burst_left--;
            end
        end
    end

    // receiver: random modes plus one long hold-off
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_hold_left = 0;
    bit rx_long_done = 1'b0;

    always @(negedge clk)
    begin
        if (!rst_n)
            token_ready <= 1'b0;
        else if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            token_ready <= 1'b0;
        end
        else if (!rx_long_done && tokens_seen >= 80)
        begin
            rx_long_done = 1'b1;
            rx_hold_left = 60;
            token_ready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(8, 64);
            end
            else
                rx_mode_left--;
            case (rx_mode)
                0: token_ready <= 1'b1;
                1: token_ready <= 1'($urandom_range(0, 1));
                default: token_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // check the outgoing token before predicting from the incoming request
    always @(posedge clk)
    begin
        result_t want;
        result_t tok;
        if (rst_n)
        begin
            byte_took <= byte_valid && byte_ready;
            if (token_valid && token_ready)
            begin
                tokens_seen++;
                if (expected_tokens.size() == 0)
                begin
                    errors++;
                    $display("%0t: token with none expected, kind %0d error_code %0d",
                             $time, kind, error_code);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    check_field("kind", 64'(want.kind), 64'(kind));
                    check_field("field_number", 64'(want.field_number), 64'(field_number));
                    check_field("wire_type", 64'(want.wire_type), 64'(wire_type));
                    check_field("field_value", want.field_value, field_value);
                    check_field("payload_byte", 64'(want.payload_byte), 64'(payload_byte));
                    check_field("payload_last", 64'(want.payload_last), 64'(payload_last));
                    check_field("error_code", 64'(want.error_code), 64'(error_code));
                    check_field("message_end", 64'(want.message_end), 64'(message_end));
                end
            end
            if (byte_valid && byte_ready)
            begin
                n_accepted++;
                if (decode_byte(data_byte, message_last, tok))
                    expected_tokens.insert(expected_tokens.size(), tok);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int         n_directed;
        int         n_total;
        int         pick;
        int         cut;
        bit         mid_hold_done;
        bit         first_random;
        logic [2:0] bad_w;

        // directed: plain scalar, every fault but an overlong varint, zero and cut-short lengths
        msg = '{8'h08, 8'h96, 8'h01};  queue_message(1'b0);
        msg = '{8'h0B, 8'h00, 8'h00};  queue_message(1'b0);
        msg = '{8'h0C};                queue_message(1'b0);
        msg = '{8'h0E};                queue_message(1'b0);
        msg = '{8'h0F};                queue_message(1'b0);
        msg = '{8'h80};                queue_message(1'b0);
        msg = '{8'h08};                queue_message(1'b0);
        msg = '{8'h12};                queue_message(1'b0);
        msg = '{8'h09};                queue_message(1'b0);
        msg = '{8'h0D};                queue_message(1'b0);
        msg = '{8'h12, 8'h00};         queue_message(1'b0);
        msg = '{8'h12, 8'h02};         queue_message(1'b0);
        msg = '{8'h12, 8'h02, 8'hAA};  queue_message(1'b0);
        msg = '{8'h0D, 8'h11};         queue_message(1'b0);
        n_directed = byte_reqs.size();

        mid_hold_done = 1'b0;
        first_random = 1'b1;
        while (byte_reqs.size() < n_directed + 450)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                repeat ($urandom_range(1, 4)) put_field();
            else if (pick < 80)
            begin
                repeat ($urandom_range(1, 3)) put_field();
                if (msg.size() > 1)
                begin
                    cut = $urandom_range(1, msg.size() - 1);
                    while (msg.size() > cut)
                        void'(msg.pop_back());
                end
            end
            else if (pick < 86)
            begin
                if ($urandom_range(0, 1))
                    put_field();
                do
                    bad_w = 3'($urandom);
                while (bad_w == WIRE_VARINT || bad_w == WIRE_I64 ||
                       bad_w == WIRE_LEN || bad_w == WIRE_I32);
                put_varint({29'd0, $urandom, bad_w}, pad_len());
                repeat ($urandom_range(0, 3)) msg.insert(msg.size(), 8'($urandom));
            end
            else if (pick < 92)
            begin
                if ($urandom_range(0, 1))
                    put_field();
                // overlong varint either as key or as value/length
                if ($urandom_range(0, 1))
                    put_varint({29'd0, 32'($urandom_range(1, 200)),
                                ($urandom_range(0, 1) ? WIRE_VARINT : WIRE_LEN)}, 0);
                repeat (10) msg.insert(msg.size(), 8'h80 | 8'($urandom_range(0, 127)));
                repeat ($urandom_range(1, 3)) msg.insert(msg.size(), 8'($urandom));
            end
            else
                repeat ($urandom_range(1, 8)) msg.insert(msg.size(), 8'($urandom));

            if (first_random)
            begin
                queue_message(1'b1);
                first_random = 1'b0;
            end
            else if (!mid_hold_done && byte_reqs.size() >= n_directed + 225)
            begin
                queue_message(1'b1);
                mid_hold_done = 1'b1;
            end
            else
                queue_message(1'b0);
        end
        n_total = byte_reqs.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (n_accepted != n_total || expected_tokens.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/pwft_pkg.sv
hw/rtl/pwft_core.sv
hw/rtl/protobuf_wire_field_tokenizer.sv
tb/tb_top.sv
